FILE: sv/rmj_pkg.sv
// Shared types and constants for the radar measurement Jacobian block.
// No dependencies; every other file of the block refers to it by scoped names.
package rmj_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ROOT_W      = 32;
  localparam int unsigned QUOT_W      = 32;
  localparam int unsigned DIV_LAT     = QUOT_W + 1;
  localparam int unsigned LIMIT_W     = 17;

  localparam logic [LIMIT_W-1:0] ORIGIN_THRESH_RST = 17'd66;

  // One classified item as it travels from the front part to the back part.
  typedef struct packed {
    logic [31:0] pxm;
    logic [31:0] pym;
    logic        px_neg;
    logic        py_neg;
    logic [63:0] r2;
    logic [63:0] cm;
    logic        c_neg;
    logic        near;
  } rmj_item_t;

endpackage

FILE: sv/radar_measurement_jacobian.sv
// Radar measurement Jacobian, top level: front part, item queue and back part.
// Depends on rmj_pkg, rmj_front, rmj_queue and rmj_back.
//
// Takes one state (px, py, vx, vy) in signed Q16.16 per transaction and returns
// the six distinct entries of the range/bearing/range-rate Jacobian, truncated
// toward zero and saturated to 32 bits, with near_origin set and all entries zero
// when both |px| and |py| are below origin_thresh (reset value 66, about 0.001).
// The block accepts one transaction per clock cycle when the output side does not stall.
// The back part holds the 32-stage square root and the 33-stage dividers.
// The origin_thresh register is written through its own channel; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module radar_measurement_jacobian #(
  parameter int unsigned QUEUE_DEPTH = rmj_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rmj_pkg::LIMIT_W-1:0]  origin_thresh_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [31:0]           pos_x_i,
  input  logic signed [31:0]           pos_y_i,
  input  logic signed [31:0]           vel_x_i,
  input  logic signed [31:0]           vel_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [17:0]           d_range_d_px_o,
  output logic signed [17:0]           d_range_d_py_o,
  output logic signed [31:0]           d_bearing_d_px_o,
  output logic signed [31:0]           d_bearing_d_py_o,
  output logic signed [31:0]           d_rate_d_px_o,
  output logic signed [31:0]           d_rate_d_py_o,
  output logic                         near_origin_o
);

  logic               fr_valid, fr_ready, bk_valid, bk_ready;
  rmj_pkg::rmj_item_t fr_item, bk_item;

  rmj_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .origin_thresh_i (origin_thresh_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .vel_x_i         (vel_x_i),
    .vel_y_i         (vel_y_i),
    .item_valid_o    (fr_valid),
    .item_ready_i    (fr_ready),
    .item_o          (fr_item)
  );

  rmj_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_item)
  );

  rmj_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (bk_valid),
    .item_ready_o     (bk_ready),
    .item_i           (bk_item),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .d_range_d_px_o   (d_range_d_px_o),
    .d_range_d_py_o   (d_range_d_py_o),
    .d_bearing_d_px_o (d_bearing_d_px_o),
    .d_bearing_d_py_o (d_bearing_d_py_o),
    .d_rate_d_px_o    (d_rate_d_px_o),
    .d_rate_d_py_o    (d_rate_d_py_o),
    .near_origin_o    (near_origin_o)
  );

endmodule

FILE: sv/rmj_front.sv
// Front part: configuration register, input handshake, magnitudes, origin test,
// squared range and cross term. Depends on rmj_pkg.
module rmj_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rmj_pkg::LIMIT_W-1:0]     origin_thresh_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [31:0]              pos_x_i,
  input  logic signed [31:0]              pos_y_i,
  input  logic signed [31:0]              vel_x_i,
  input  logic signed [31:0]              vel_y_i,
  output logic                            item_valid_o,
  input  logic                            item_ready_i,
  output rmj_pkg::rmj_item_t              item_o
);

  logic [rmj_pkg::LIMIT_W-1:0] zl_q;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  logic [31:0] pxm, pym;
  logic        near;

  logic [31:0]        s1_pxm_q, s1_pym_q;
  logic               s1_pxn_q, s1_pyn_q, s1_near_q;
  logic signed [31:0] s1_px_q, s1_py_q, s1_vx_q, s1_vy_q;

  logic [63:0]        s2_pxx_d, s2_pyy_d, s2_pxx_q, s2_pyy_q;
  logic signed [63:0] s2_vxpy_d, s2_vypx_d, s2_vxpy_q, s2_vypx_q;
  logic [31:0]        s2_pxm_q, s2_pym_q;
  logic               s2_pxn_q, s2_pyn_q, s2_near_q;

  logic [64:0]        c_full;
  rmj_pkg::rmj_item_t s3_d, s3_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zl_q <= rmj_pkg::ORIGIN_THRESH_RST;
    end else if (cfg_valid_i) begin
      zl_q <= origin_thresh_i;
    end
  end

  assign rdy3         = !v3_q || item_ready_i;
  assign rdy2         = !v2_q || rdy3;
  assign rdy1         = !v1_q || rdy2;
  assign in_ready_o   = rdy1;
  assign item_valid_o = v3_q;
  assign item_o       = s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_comb begin
    pxm  = pos_x_i[31] ? (~pos_x_i + 32'd1) : pos_x_i;
    pym  = pos_y_i[31] ? (~pos_y_i + 32'd1) : pos_y_i;
    // The exact origin counts as near even when the limit is zero.
    near = (pxm < {15'd0, zl_q} && pym < {15'd0, zl_q}) || (pxm == 32'd0 && pym == 32'd0);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_pxm_q  <= pxm;
      s1_pym_q  <= pym;
      s1_pxn_q  <= pos_x_i[31];
      s1_pyn_q  <= pos_y_i[31];
      s1_near_q <= near;
      s1_px_q   <= pos_x_i;
      s1_py_q   <= pos_y_i;
      s1_vx_q   <= vel_x_i;
      s1_vy_q   <= vel_y_i;
    end
  end

  assign s2_pxx_d  = s1_pxm_q * s1_pxm_q;
  assign s2_pyy_d  = s1_pym_q * s1_pym_q;
  assign s2_vxpy_d = s1_vx_q * s1_py_q;
  assign s2_vypx_d = s1_vy_q * s1_px_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_pxx_q  <= s2_pxx_d;
      s2_pyy_q  <= s2_pyy_d;
      s2_vxpy_q <= s2_vxpy_d;
      s2_vypx_q <= s2_vypx_d;
      s2_pxm_q  <= s1_pxm_q;
      s2_pym_q  <= s1_pym_q;
      s2_pxn_q  <= s1_pxn_q;
      s2_pyn_q  <= s1_pyn_q;
      s2_near_q <= s1_near_q;
    end
  end

  always_comb begin
    c_full        = {s2_vxpy_q[63], s2_vxpy_q} - {s2_vypx_q[63], s2_vypx_q};
    s3_d.pxm      = s2_pxm_q;
    s3_d.pym      = s2_pym_q;
    s3_d.px_neg   = s2_pxn_q;
    s3_d.py_neg   = s2_pyn_q;
    s3_d.r2       = s2_pxx_q + s2_pyy_q;
    s3_d.c_neg    = c_full[64];
    s3_d.cm       = c_full[64] ? (~c_full[63:0] + 64'd1) : c_full[63:0];
    s3_d.near     = s2_near_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_q <= s3_d;
    end
  end

endmodule

FILE: sv/rmj_queue.sv
// Short queue of classified items between the front and back parts.
// Depends on rmj_pkg for the item type.
module rmj_queue #(
  parameter int unsigned DEPTH = rmj_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  rmj_pkg::rmj_item_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output rmj_pkg::rmj_item_t pop_data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rmj_pkg::rmj_item_t mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               push, pop;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: sv/rmj_div.sv
// Pipelined restoring divider, one quotient bit per stage, with signed
// saturation of the 32-bit result. Depends on rmj_pkg.
module rmj_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 32
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [NUM_W-1:0]            num_i,
  input  logic [DEN_W-1:0]            den_i,
  input  logic                        neg_i,
  output logic [rmj_pkg::QUOT_W-1:0]  quot_o
);

  localparam int unsigned QW = rmj_pkg::QUOT_W;
  localparam logic [QW-1:0] MIN_MAG = {1'b1, {(QW - 1){1'b0}}};

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QW-1:0]    rq;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             ovf;
  } st_t;

  st_t st_q [QW + 1];
  st_t st0_d;
  logic [QW-1:0] mag;

  // A quotient of 2^32 or more is caught up front and only saturates.
  always_comb begin
    st0_d.rem = DEN_W'(num_i[NUM_W-1:QW]);
    st0_d.ovf = DEN_W'(num_i[NUM_W-1:QW]) >= den_i;
    st0_d.rq  = num_i[QW-1:0];
    st0_d.den = den_i;
    st0_d.neg = neg_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= st0_d;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    logic [DEN_W:0] cand, diff;
    logic           ge;
    st_t            nxt;

    always_comb begin
      cand    = {st_q[s-1].rem, st_q[s-1].rq[QW-1]};
      diff    = cand - {1'b0, st_q[s-1].den};
      ge      = cand >= {1'b0, st_q[s-1].den};
      nxt     = st_q[s-1];
      nxt.rem = ge ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
      nxt.rq  = {st_q[s-1].rq[QW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= nxt;
      end
    end
  end

  always_comb begin
    mag = (st_q[QW].ovf || st_q[QW].rq > MIN_MAG) ? MIN_MAG : st_q[QW].rq;
    if (!st_q[QW].neg && mag[QW-1]) begin
      mag = MIN_MAG - 1'b1;
    end
    quot_o = st_q[QW].neg ? (~mag + 1'b1) : mag;
  end

endmodule

FILE: sv/rmj_back.sv
// Back part: pipelined square root, wide products, six dividers and the output
// register. Depends on rmj_pkg and rmj_div.
module rmj_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  rmj_pkg::rmj_item_t  item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [17:0]  d_range_d_px_o,
  output logic signed [17:0]  d_range_d_py_o,
  output logic signed [31:0]  d_bearing_d_px_o,
  output logic signed [31:0]  d_bearing_d_py_o,
  output logic signed [31:0]  d_rate_d_px_o,
  output logic signed [31:0]  d_rate_d_py_o,
  output logic                near_origin_o
);

  localparam int unsigned RW   = rmj_pkg::ROOT_W;
  localparam int unsigned REMW = RW + 2;
  localparam int unsigned DL   = rmj_pkg::DIV_LAT;

  typedef struct packed {
    rmj_pkg::rmj_item_t item;
    logic [REMW-1:0]    rem;
    logic [RW-1:0]      root;
  } sq_t;

  logic en;
  sq_t  sq_q [RW];
  logic sq_v_q [RW];

  rmj_pkg::rmj_item_t m1_item_q, m2_item_q;
  logic [RW-1:0]      m1_root_q, m2_root_q;
  logic [63:0]        m1_den_lo_q, m1_den_hi_q, m1_ny_lo_q, m1_ny_hi_q, m1_nx_lo_q, m1_nx_hi_q;
  logic [95:0]        m2_den3_q, m2_ny_q, m2_nx_q;
  logic               m1_v_q, m2_v_q;

  logic dv_q [DL];
  logic nr_q [DL];

  logic [31:0] q_rx, q_ry, q_bx, q_by, q_cx, q_cy;
  logic        neg_bx, neg_cx, neg_cy;

  logic               out_valid_q, out_near_q;
  logic signed [17:0] out_rx_q, out_ry_q;
  logic signed [31:0] out_bx_q, out_by_q, out_cx_q, out_cy_q;

  // The whole back pipeline advances together whenever the output can move.
  assign en           = !out_valid_q || out_ready_i;
  assign item_ready_o = en;

  for (genvar k = 0; k < RW; k++) begin : g_sq
    rmj_pkg::rmj_item_t in_item;
    logic [REMW-1:0]    in_rem;
    logic [RW-1:0]      in_root;
    logic               in_v;
    logic [REMW+1:0]    cand, trial;
    logic               ge;
    sq_t                nxt;

    if (k == 0) begin : g_head
      assign in_item = item_i;
      assign in_rem  = '0;
      assign in_root = '0;
      assign in_v    = item_valid_i;
    end else begin : g_tail
      assign in_item = sq_q[k-1].item;
      assign in_rem  = sq_q[k-1].rem;
      assign in_root = sq_q[k-1].root;
      assign in_v    = sq_v_q[k-1];
    end

    always_comb begin
      cand     = {in_rem, in_item.r2[2*(RW-1-k)+1 -: 2]};
      trial    = (REMW + 2)'({in_root, 2'b01});
      ge       = cand >= trial;
      nxt.item = in_item;
      nxt.rem  = ge ? REMW'(cand - trial) : REMW'(cand);
      nxt.root = {in_root[RW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[k] <= nxt;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else if (en) begin
        sq_v_q[k] <= in_v;
      end
    end
  end

  // Products are split into 32x32 halves in the m1 registers and summed into the m2 registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_item_q   <= sq_q[RW-1].item;
      m1_root_q   <= sq_q[RW-1].root;
      m1_den_lo_q <= sq_q[RW-1].item.r2[31:0] * sq_q[RW-1].root;
      m1_den_hi_q <= sq_q[RW-1].item.r2[63:32] * sq_q[RW-1].root;
      m1_ny_lo_q  <= sq_q[RW-1].item.pym * sq_q[RW-1].item.cm[31:0];
      m1_ny_hi_q  <= sq_q[RW-1].item.pym * sq_q[RW-1].item.cm[63:32];
      m1_nx_lo_q  <= sq_q[RW-1].item.pxm * sq_q[RW-1].item.cm[31:0];
      m1_nx_hi_q  <= sq_q[RW-1].item.pxm * sq_q[RW-1].item.cm[63:32];
      m2_item_q   <= m1_item_q;
      m2_root_q   <= m1_root_q;
      m2_den3_q   <= {m1_den_hi_q, 32'd0} + {32'd0, m1_den_lo_q};
      m2_ny_q     <= {m1_ny_hi_q, 32'd0} + {32'd0, m1_ny_lo_q};
      m2_nx_q     <= {m1_nx_hi_q, 32'd0} + {32'd0, m1_nx_lo_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= sq_v_q[RW-1];
      m2_v_q <= m1_v_q;
    end
  end

  assign neg_bx = !m2_item_q.py_neg && (m2_item_q.pym != 32'd0);
  assign neg_cx = m2_item_q.py_neg != m2_item_q.c_neg;
  assign neg_cy = m2_item_q.px_neg == m2_item_q.c_neg;

  rmj_div #(.NUM_W(48), .DEN_W(RW)) u_div_rx (
    .clk_i(clk_i), .en_i(en), .num_i({m2_item_q.pxm, 16'd0}), .den_i(m2_root_q),
    .neg_i(m2_item_q.px_neg), .quot_o(q_rx)
  );

  rmj_div #(.NUM_W(48), .DEN_W(RW)) u_div_ry (
    .clk_i(clk_i), .en_i(en), .num_i({m2_item_q.pym, 16'd0}), .den_i(m2_root_q),
    .neg_i(m2_item_q.py_neg), .quot_o(q_ry)
  );

  rmj_div #(.NUM_W(64), .DEN_W(64)) u_div_bx (
    .clk_i(clk_i), .en_i(en), .num_i({m2_item_q.pym, 32'd0}), .den_i(m2_item_q.r2),
    .neg_i(neg_bx), .quot_o(q_bx)
  );

  rmj_div #(.NUM_W(64), .DEN_W(64)) u_div_by (
    .clk_i(clk_i), .en_i(en), .num_i({m2_item_q.pxm, 32'd0}), .den_i(m2_item_q.r2),
    .neg_i(m2_item_q.px_neg), .quot_o(q_by)
  );

  rmj_div #(.NUM_W(112), .DEN_W(96)) u_div_cx (
    .clk_i(clk_i), .en_i(en), .num_i({m2_ny_q, 16'd0}), .den_i(m2_den3_q),
    .neg_i(neg_cx), .quot_o(q_cx)
  );

  rmj_div #(.NUM_W(112), .DEN_W(96)) u_div_cy (
    .clk_i(clk_i), .en_i(en), .num_i({m2_nx_q, 16'd0}), .den_i(m2_den3_q),
    .neg_i(neg_cy), .quot_o(q_cy)
  );

  // Valid and near-origin flags ride alongside the divider stages.
  for (genvar j = 0; j < DL; j++) begin : g_side
    logic in_dv, in_nr;

    if (j == 0) begin : g_head
      assign in_dv = m2_v_q;
      assign in_nr = m2_item_q.near;
    end else begin : g_tail
      assign in_dv = dv_q[j-1];
      assign in_nr = nr_q[j-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        nr_q[j] <= in_nr;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (en) begin
        dv_q[j] <= in_dv;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_q[DL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_near_q <= nr_q[DL-1];
      out_rx_q   <= nr_q[DL-1] ? '0 : $signed(q_rx[17:0]);
      out_ry_q   <= nr_q[DL-1] ? '0 : $signed(q_ry[17:0]);
      out_bx_q   <= nr_q[DL-1] ? '0 : $signed(q_bx);
      out_by_q   <= nr_q[DL-1] ? '0 : $signed(q_by);
      out_cx_q   <= nr_q[DL-1] ? '0 : $signed(q_cx);
      out_cy_q   <= nr_q[DL-1] ? '0 : $signed(q_cy);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign near_origin_o    = out_near_q;
  assign d_range_d_px_o   = out_rx_q;
  assign d_range_d_py_o   = out_ry_q;
  assign d_bearing_d_px_o = out_bx_q;
  assign d_bearing_d_py_o = out_by_q;
  assign d_rate_d_px_o    = out_cx_q;
  assign d_rate_d_py_o    = out_cy_q;

  a_near_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && near_origin_o |-> d_range_d_px_o == '0 && d_range_d_py_o == '0 &&
      d_bearing_d_px_o == '0 && d_bearing_d_py_o == '0 && d_rate_d_px_o == '0 &&
      d_rate_d_py_o == '0)
    else $error("near-origin transaction carries nonzero entries");

  a_rx_unit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> d_range_d_px_o <= 18'sd65536 && d_range_d_px_o >= -18'sd65536)
    else $error("px over r exceeds one in magnitude");

  a_ry_unit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> d_range_d_py_o <= 18'sd65536 && d_range_d_py_o >= -18'sd65536)
    else $error("py over r exceeds one in magnitude");

endmodule
